// ----- src/b64_pkg.sv -----
// ----------------------------------------------------------------------------
// b64_pkg: shared types and constants of the base64 stream codec
// Request codes, status codes, the queue item, the alphabet unit's request and
// response bundles, and the reset alphabet.
// ----------------------------------------------------------------------------
package b64_pkg;

  // Alphabet geometry
  localparam int ALPHA_DEPTH = 64;
  localparam int ALPHA_IDX_W = 6;
  localparam int GROUP_SIZE  = 8;
  localparam int NUM_GROUPS  = ALPHA_DEPTH / GROUP_SIZE;
  localparam int GROUP_IDX_W = 3;

  // Results one item can cause
  localparam int MAX_RESULTS = 4;
  localparam int RES_CNT_W   = 3;
  localparam int RES_SLOT_W  = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3d;  // '='

  // Request type codes on the input channel
  localparam logic [1:0] REQ_ENCODE = 2'd0;
  localparam logic [1:0] REQ_DECODE = 2'd1;
  localparam logic [1:0] REQ_WRITE  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    OP_ENCODE,
    OP_DECODE,
    OP_WRITE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_CHAR,
    ST_BAD_LEN,
    ST_BAD_PAD
  } status_t;

  // Classified item held in the input queue
  typedef struct packed {
    op_t                    op;
    logic [7:0]             data;
    logic                   last;
    logic [ALPHA_IDX_W-1:0] index;
    logic                   is_pad;
  } item_t;

  // Back end to alphabet unit
  typedef struct packed {
    logic                   advance;
    logic [7:0]             query;
    logic                   wr_en;
    logic [ALPHA_IDX_W-1:0] wr_index;
    logic [7:0]             wr_value;
    logic [ALPHA_IDX_W-1:0] rd_addr0;
    logic [ALPHA_IDX_W-1:0] rd_addr1;
  } alpha_req_t;

  // Alphabet unit to back end
  typedef struct packed {
    logic [NUM_GROUPS-1:0]                  grp_hit;
    logic [NUM_GROUPS-1:0][GROUP_IDX_W-1:0] grp_idx;
    logic [7:0]                             rd_char0;
    logic [7:0]                             rd_char1;
  } alpha_rsp_t;

  // Standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [7:0] std_char(input logic [ALPHA_IDX_W-1:0] six);
    logic [7:0] c;
    if (six < 6'd26) begin
      c = 8'h41 + {2'b00, six};
    end else if (six < 6'd52) begin
      c = 8'h61 + {2'b00, six} - 8'd26;
    end else if (six < 6'd62) begin
      c = 8'h30 + {2'b00, six} - 8'd52;
    end else if (six == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

endpackage

// ----- src/b64_stream_if.sv -----
// ----------------------------------------------------------------------------
// b64_stream_if: request and result channels of the base64 stream codec
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface b64_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       last_item;
  logic [5:0] table_index;

  modport source (output valid, req_type, data_byte, last_item, table_index,
                  input ready);
  modport sink (input valid, req_type, data_byte, last_item, table_index,
                output ready);
endinterface

interface b64_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       message_end;
  logic [1:0] status;

  modport source (output valid, out_byte, run_end, message_end, status,
                  input ready);
  modport sink (input valid, out_byte, run_end, message_end, status,
                output ready);
endinterface

// ----- src/b64_front.sv -----
// ----------------------------------------------------------------------------
// b64_front: request intake and queue
// Takes request items, classifies them and queues them for the back end.
// Items of the unused request type are taken and dropped.
// ----------------------------------------------------------------------------
module b64_front #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  b64_req_if.sink         request,
  input  logic            pop,
  output logic            head_valid,
  output b64_pkg::item_t  head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64_pkg::item_t slots [DEPTH];
  b64_pkg::item_t in_item;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             accept;
  logic             push;

  assign request.ready = (count != CNT_W'(DEPTH));
  assign accept        = request.valid && request.ready;
  assign push          = accept && (request.req_type != b64_pkg::REQ_UNUSED);
  assign head_valid    = (count != '0);
  assign head_item     = slots[rd_ptr];

  // Classify the incoming item
  always_comb begin
    in_item.data   = request.data_byte;
    in_item.last   = request.last_item;
    in_item.index  = request.table_index;
    in_item.is_pad = (request.data_byte == b64_pkg::PAD_CHAR);
    unique case (request.req_type)
      b64_pkg::REQ_ENCODE: in_item.op = b64_pkg::OP_ENCODE;
      b64_pkg::REQ_DECODE: in_item.op = b64_pkg::OP_DECODE;
      default:             in_item.op = b64_pkg::OP_WRITE;
    endcase
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/b64_alpha.sv -----
// ----------------------------------------------------------------------------
// b64_alpha: writable alphabet
// A CAM copy of the alphabet serves decode lookups (highest matching index
// wins, resolved per group of eight); a memory copy with per-entry valid bits
// serves encode lookups on two read ports.
// ----------------------------------------------------------------------------
module b64_alpha (
  input  logic                 clk,
  input  logic                 rst,
  input  b64_pkg::alpha_req_t  req,
  output b64_pkg::alpha_rsp_t  rsp
);

  localparam int DEPTH  = b64_pkg::ALPHA_DEPTH;
  localparam int GSIZE  = b64_pkg::GROUP_SIZE;
  localparam int NGRP   = b64_pkg::NUM_GROUPS;
  localparam int GIDX_W = b64_pkg::GROUP_IDX_W;
  localparam int AW     = b64_pkg::ALPHA_IDX_W;

  logic [7:0]                   cam [DEPTH];
  logic [7:0]                   enc_mem [DEPTH];
  logic [DEPTH-1:0]             enc_vld;
  logic [NGRP-1:0]              hit_c;
  logic [NGRP-1:0][GIDX_W-1:0]  idx_c;
  logic [NGRP-1:0]              grp_hit;
  logic [NGRP-1:0][GIDX_W-1:0]  grp_idx;
  logic [7:0]                   rd_data0;
  logic [7:0]                   rd_data1;
  logic                         rd_vld0;
  logic                         rd_vld1;
  logic [AW-1:0]                rd_addr0_q;
  logic [AW-1:0]                rd_addr1_q;

  // CAM entries, reset to the standard alphabet
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        cam[i] <= b64_pkg::std_char(AW'(i));
      end
    end else if (req.wr_en) begin
      cam[req.wr_index] <= req.wr_value;
    end
  end

  // Per-group match: highest matching entry in each group of eight
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      hit_c[g] = 1'b0;
      idx_c[g] = '0;
      for (int j = 0; j < GSIZE; j++) begin
        if (cam[g * GSIZE + j] == req.query) begin
          hit_c[g] = 1'b1;
          idx_c[g] = GIDX_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.advance) begin
      grp_hit <= hit_c;
      grp_idx <= idx_c;
    end
  end

  // Encode copy: entries never written read as the standard alphabet
  always_ff @(posedge clk) begin
    if (rst) begin
      enc_vld <= '0;
    end else if (req.wr_en) begin
      enc_vld[req.wr_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      enc_mem[req.wr_index] <= req.wr_value;
    end
    if (req.advance) begin
      rd_data0   <= enc_mem[req.rd_addr0];
      rd_data1   <= enc_mem[req.rd_addr1];
      rd_vld0    <= enc_vld[req.rd_addr0];
      rd_vld1    <= enc_vld[req.rd_addr1];
      rd_addr0_q <= req.rd_addr0;
      rd_addr1_q <= req.rd_addr1;
    end
  end

  assign rsp.grp_hit  = grp_hit;
  assign rsp.grp_idx  = grp_idx;
  assign rsp.rd_char0 = rd_vld0 ? rd_data0 : b64_pkg::std_char(rd_addr0_q);
  assign rsp.rd_char1 = rd_vld1 ? rd_data1 : b64_pkg::std_char(rd_addr1_q);

endmodule

// ----- src/b64_back.sv -----
// ----------------------------------------------------------------------------
// b64_back: codec execution pipeline
// S1 does the alphabet write and the CAM compare, S2 holds the encoder and
// decoder state and plans the results, S3 hands them one per cycle to the
// output register while that register is free.
// ----------------------------------------------------------------------------
module b64_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  b64_pkg::item_t       head_item,
  output logic                 pop,
  output b64_pkg::alpha_req_t  alpha_req,
  input  b64_pkg::alpha_rsp_t  alpha_rsp,
  b64_res_if.source            result
);

  localparam int CNT_W  = b64_pkg::RES_CNT_W;
  localparam int SLOT_W = b64_pkg::RES_SLOT_W;
  localparam int NRES   = b64_pkg::MAX_RESULTS;
  localparam int NGRP   = b64_pkg::NUM_GROUPS;
  localparam int GIDX_W = b64_pkg::GROUP_IDX_W;
  localparam int AW     = b64_pkg::ALPHA_IDX_W;

  // Pipeline registers
  logic                  s1_vld;
  b64_pkg::item_t        s1_item;
  logic                  s2_vld;
  b64_pkg::item_t        s2_item;
  logic                  s3_vld;
  logic [CNT_W-1:0]      s3_cnt;
  logic [SLOT_W-1:0]     s3_slot;
  logic                  s3_enc;
  logic [NRES-1:0][7:0]  s3_bytes;
  b64_pkg::status_t      s3_status;
  logic                  s3_msg_end;

  // Codec state
  logic [1:0]            enc_phase;
  logic [3:0]            enc_held;
  logic [1:0]            dec_pos;
  logic [17:0]           dec_sext;
  logic [1:0]            dec_pad;
  logic                  dec_drop;

  logic [1:0]            enc_phase_next;
  logic [3:0]            enc_held_next;
  logic [1:0]            dec_pos_next;
  logic [17:0]           dec_sext_next;
  logic [1:0]            dec_pad_next;
  logic                  dec_drop_next;

  // Output register
  logic                  o_vld;
  logic [7:0]            o_byte;
  logic                  o_run_end;
  logic                  o_msg_end;
  b64_pkg::status_t      o_status;

  // S2 plan
  logic [CNT_W-1:0]      plan_cnt;
  logic                  plan_enc;
  logic [NRES-1:0][7:0]  plan_bytes;
  b64_pkg::status_t      plan_status;
  logic                  plan_msg_end;
  logic [AW-1:0]         rd_addr0;
  logic [AW-1:0]         rd_addr1;

  logic                  found;
  logic [AW-1:0]         six;
  logic [AW-1:0]         six_eff;
  logic [1:0]            pad_inc;
  b64_pkg::status_t      err;
  logic                  bad_pad_tail;

  logic                  out_free;
  logic                  out_load;
  logic                  slot_last;
  logic                  s3_done;
  logic                  advance;
  logic [7:0]            slot_byte;

  // Stage flow: S3 releases once its last result is loaded into the output register, or at once if it has none
  assign slot_last = ({1'b0, s3_slot} == (s3_cnt - 1'b1));
  assign out_free  = !o_vld || result.ready;
  assign out_load  = s3_vld && (s3_cnt != '0) && out_free;
  assign s3_done   = s3_vld && ((s3_cnt == '0) || (out_load && slot_last));
  assign advance   = !s3_vld || s3_done;
  assign pop       = advance && head_valid;

  // Alphabet unit requests
  always_comb begin
    alpha_req.advance  = advance;
    alpha_req.query    = s1_item.data;
    alpha_req.wr_en    = advance && s1_vld && (s1_item.op == b64_pkg::OP_WRITE);
    alpha_req.wr_index = s1_item.index;
    alpha_req.wr_value = s1_item.data;
    alpha_req.rd_addr0 = rd_addr0;
    alpha_req.rd_addr1 = rd_addr1;
  end

  // Resolve the CAM groups: highest group with a hit wins
  always_comb begin
    found = 1'b0;
    six   = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (alpha_rsp.grp_hit[g]) begin
        found = 1'b1;
        six   = {GIDX_W'(g), alpha_rsp.grp_idx[g]};
      end
    end
  end

  // Decode error check, in priority order
  assign bad_pad_tail = s2_item.is_pad || (dec_pad != 2'd0);
  always_comb begin
    if (!s2_item.is_pad && !found) begin
      err = b64_pkg::ST_BAD_CHAR;
    end else if (s2_item.is_pad && (dec_pos < 2'd2)) begin
      err = b64_pkg::ST_BAD_PAD;
    end else if (!s2_item.is_pad && (dec_pad != 2'd0)) begin
      err = b64_pkg::ST_BAD_PAD;
    end else if ((dec_pos == 2'd3) && !s2_item.last && bad_pad_tail) begin
      err = b64_pkg::ST_BAD_PAD;
    end else if (s2_item.last && (dec_pos != 2'd3)) begin
      err = b64_pkg::ST_BAD_LEN;
    end else begin
      err = b64_pkg::ST_OK;
    end
  end

  assign six_eff = s2_item.is_pad ? '0 : six;
  assign pad_inc = s2_item.is_pad ? dec_pad + 2'd1 : dec_pad;

  // S2: state update and result plan
  always_comb begin
    enc_phase_next = enc_phase;
    enc_held_next  = enc_held;
    dec_pos_next   = dec_pos;
    dec_sext_next  = dec_sext;
    dec_pad_next   = dec_pad;
    dec_drop_next  = dec_drop;
    plan_cnt       = '0;
    plan_enc       = 1'b0;
    plan_bytes     = {NRES{b64_pkg::PAD_CHAR}};
    plan_status    = b64_pkg::ST_OK;
    plan_msg_end   = s2_item.last;
    rd_addr0       = '0;
    rd_addr1       = '0;
    if (s2_vld) begin
      case (s2_item.op)
        b64_pkg::OP_ENCODE: begin
          plan_enc = 1'b1;
          case (enc_phase)
            2'd0: begin
              rd_addr0 = s2_item.data[7:2];
              rd_addr1 = {s2_item.data[1:0], 4'b0000};
              if (s2_item.last) begin
                plan_cnt = CNT_W'(4);
              end else begin
                plan_cnt       = CNT_W'(1);
                enc_phase_next = 2'd1;
                enc_held_next  = {2'b00, s2_item.data[1:0]};
              end
            end
            2'd1: begin
              rd_addr0 = {enc_held[1:0], s2_item.data[7:4]};
              rd_addr1 = {s2_item.data[3:0], 2'b00};
              if (s2_item.last) begin
                plan_cnt       = CNT_W'(3);
                enc_phase_next = 2'd0;
                enc_held_next  = '0;
              end else begin
                plan_cnt       = CNT_W'(1);
                enc_phase_next = 2'd2;
                enc_held_next  = s2_item.data[3:0];
              end
            end
            default: begin
              rd_addr0       = {enc_held, s2_item.data[7:6]};
              rd_addr1       = s2_item.data[5:0];
              plan_cnt       = CNT_W'(2);
              enc_phase_next = 2'd0;
              enc_held_next  = '0;
            end
          endcase
        end
        b64_pkg::OP_DECODE: begin
          if (dec_drop) begin
            if (s2_item.last) begin
              dec_drop_next = 1'b0;
            end
          end else if (err != b64_pkg::ST_OK) begin
            plan_cnt      = CNT_W'(1);
            plan_bytes[0] = 8'h00;
            plan_status   = err;
            plan_msg_end  = 1'b1;
            dec_pos_next  = '0;
            dec_sext_next = '0;
            dec_pad_next  = '0;
            dec_drop_next = !s2_item.last;
          end else if (dec_pos != 2'd3) begin
            dec_sext_next = {dec_sext[11:0], six_eff};
            dec_pos_next  = dec_pos + 2'd1;
            dec_pad_next  = pad_inc;
          end else begin
            // Quad complete: emit 3, 2 or 1 bytes
            plan_bytes[0] = {dec_sext[17:12], dec_sext[11:10]};
            plan_bytes[1] = {dec_sext[9:6], dec_sext[5:2]};
            plan_bytes[2] = {dec_sext[1:0], six_eff};
            if (pad_inc >= 2'd2) begin
              plan_cnt = CNT_W'(1);
            end else if (pad_inc == 2'd1) begin
              plan_cnt = CNT_W'(2);
            end else begin
              plan_cnt = CNT_W'(3);
            end
            dec_pos_next  = '0;
            dec_sext_next = '0;
            dec_pad_next  = '0;
          end
        end
        default: begin
          plan_cnt = '0;
        end
      endcase
    end
  end

  // S3 slot select: first two encode slots come from the alphabet reads
  always_comb begin
    if (s3_enc && (s3_slot == 2'd0)) begin
      slot_byte = alpha_rsp.rd_char0;
    end else if (s3_enc && (s3_slot == 2'd1)) begin
      slot_byte = alpha_rsp.rd_char1;
    end else begin
      slot_byte = s3_bytes[s3_slot];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      s3_vld    <= 1'b0;
      s3_slot   <= '0;
      enc_phase <= '0;
      enc_held  <= '0;
      dec_pos   <= '0;
      dec_sext  <= '0;
      dec_pad   <= '0;
      dec_drop  <= 1'b0;
      o_vld     <= 1'b0;
    end else begin
      if (advance) begin
        s1_vld    <= head_valid;
        s2_vld    <= s1_vld;
        s3_vld    <= s2_vld;
        s3_slot   <= '0;
        enc_phase <= enc_phase_next;
        enc_held  <= enc_held_next;
        dec_pos   <= dec_pos_next;
        dec_sext  <= dec_sext_next;
        dec_pad   <= dec_pad_next;
        dec_drop  <= dec_drop_next;
      end else if (out_load) begin
        s3_slot <= s3_slot + 1'b1;
      end
      if (out_load) begin
        o_vld <= 1'b1;
      end else if (result.ready) begin
        o_vld <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item    <= head_item;
      s2_item    <= s1_item;
      s3_cnt     <= plan_cnt;
      s3_enc     <= plan_enc;
      s3_bytes   <= plan_bytes;
      s3_status  <= plan_status;
      s3_msg_end <= plan_msg_end;
    end
    if (out_load) begin
      o_byte    <= slot_byte;
      o_run_end <= slot_last;
      o_msg_end <= slot_last && s3_msg_end;
      o_status  <= s3_status;
    end
  end

  assign result.valid       = o_vld;
  assign result.out_byte    = o_byte;
  assign result.run_end     = o_run_end;
  assign result.message_end = o_msg_end;
  assign result.status      = o_status;

endmodule

// ----- src/base64_stream_codec_unit.sv -----
// ----------------------------------------------------------------------------
// base64_stream_codec_unit: streaming base64 encoder/decoder
// Base64 codec with a 64-entry writable alphabet and per-message error checks.
//
// Use:
//   request carries one item per handshake: an encode byte, a decode
//   character or an alphabet write (req_type, data_byte, last_item,
//   table_index). result carries one output character or byte per handshake
//   with run_end on the last result of an item and message_end on the last
//   result of a message; an error gives a single zero result with its status.
//   The first result of an item passes the queue, compare, state and
//   serializer stages and the output register before it shows on result.
//   One item enters the pipeline per cycle while the serializer stage is
//   free; that stage holds an item until each result that the item causes
//   has been loaded into the output register.
//   Alphabet writes apply in order with the items around them.
//   Reset clears the queue, pipeline and codec state and restores the
//   standard alphabet at once. When result is stalled the output holds,
//   the pipeline stops and the queue fills, then request.ready drops.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  b64_req_if.sink    request,
  b64_res_if.source  result
);

  logic                 head_valid;
  b64_pkg::item_t       head_item;
  logic                 pop;
  b64_pkg::alpha_req_t  alpha_req;
  b64_pkg::alpha_rsp_t  alpha_rsp;

  b64_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  b64_alpha u_alpha (
    .clk (clk),
    .rst (rst),
    .req (alpha_req),
    .rsp (alpha_rsp)
  );

  b64_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .alpha_req  (alpha_req),
    .alpha_rsp  (alpha_rsp),
    .result     (result)
  );

endmodule

// ----- src/b64_checker.sv -----
// ----------------------------------------------------------------------------
// b64_checker: port-level checks of the base64 stream codec
// Watches the request and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
module b64_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] out_byte,
  input logic       run_end,
  input logic       message_end,
  input logic [1:0] status
);

  // Reset empties the result side and opens the request side
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!res_valid && in_ready))
    else $error("result valid or request blocked after reset");

  // An error result is a lone zero result that closes its message
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status != b64_pkg::ST_OK)) |->
      ((out_byte == 8'h00) && run_end && message_end))
    else $error("error result is not a closing zero result");

  // The end of a message is also the end of its item's results
  a_msg_end_run_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && message_end) |-> run_end)
    else $error("message_end without run_end");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(out_byte) && $stable(status) &&
       $stable(run_end) && $stable(message_end)))
    else $error("stalled result changed");

endmodule

bind base64_stream_codec_unit b64_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (request.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .out_byte    (result.out_byte),
  .run_end     (result.run_end),
  .message_end (result.message_end),
  .status      (result.status)
);
